// File: hw/rtl/qbdp_pkg.sv
package qbdp_pkg;

    // Field widths
    localparam int PARTS     = 4;
    localparam int BYTE_W    = 8;
    localparam int WGT_W     = 7;   // unpacked weight, -32..31 or -1..2
    localparam int PROD1_W   = 15;  // weight * activation
    localparam int PROD2_W   = 23;  // weight * activation * scale
    localparam int SUM_W     = 30;

    // Weight decode constants
    localparam logic [WGT_W-1:0] TERN_BIAS = 7'd1;
    localparam logic [WGT_W-1:0] SIX_BIAS  = 7'd32;

    // Defaults
    localparam int LANES_PER_BLOCK_DEF = 64;
    localparam int QUEUE_DEPTH         = 4;

    // Weight format register codes
    typedef enum logic {
        FMT_TERNARY = 1'b0,
        FMT_SIX_BIT = 1'b1
    } t_fmt;

    // One classified lane, as it sits in the queue
    typedef struct packed {
        t_fmt                         fmt;
        logic                         blk_end;
        logic [PARTS-1:0][WGT_W-1:0]  wgt;
        logic [PARTS-1:0][BYTE_W-1:0] act;
        logic [PARTS-1:0][BYTE_W-1:0] scl;
    } t_lane_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hw/rtl/qbdp_if.sv
// Lane channel: one word per lane of a weight block
interface qbdp_lane_if;
    logic              valid;
    logic              ready;
    logic [7:0]        low_byte_a;
    logic [7:0]        low_byte_b;
    logic [7:0]        high_byte;
    logic signed [7:0] act_part0;
    logic signed [7:0] act_part1;
    logic signed [7:0] act_part2;
    logic signed [7:0] act_part3;
    logic signed [7:0] scale_part0;
    logic signed [7:0] scale_part1;
    logic signed [7:0] scale_part2;
    logic signed [7:0] scale_part3;
    logic              last_lane;

    modport source (
        output valid, low_byte_a, low_byte_b, high_byte,
               act_part0, act_part1, act_part2, act_part3,
               scale_part0, scale_part1, scale_part2, scale_part3, last_lane,
        input  ready
    );
    modport sink (
        input  valid, low_byte_a, low_byte_b, high_byte,
               act_part0, act_part1, act_part2, act_part3,
               scale_part0, scale_part1, scale_part2, scale_part3, last_lane,
        output ready
    );
endinterface

// Result channel: one word per finished block
interface qbdp_sum_if;
    logic               valid;
    logic               ready;
    logic signed [29:0] block_sum;

    modport source (output valid, block_sum, input ready);
    modport sink (input valid, block_sum, output ready);
endinterface

// Configuration write channel: weight format register
interface qbdp_cfg_if;
    logic valid;
    logic ready;
    logic weight_format;

    modport source (output valid, weight_format, input ready);
    modport sink (input valid, weight_format, output ready);
endinterface

// File: hw/rtl/qbdp_front.sv
module qbdp_front
    import qbdp_pkg::*;
#(
    parameter int LANES_PER_BLOCK = LANES_PER_BLOCK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fmt        i_fmt,
    qbdp_lane_if.sink   i_lane,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_lane_entry o_entry
);

    localparam int CNT_W = (LANES_PER_BLOCK > 1) ? $clog2(LANES_PER_BLOCK) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LANES_PER_BLOCK - 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             blk_end;
    logic [PARTS-1:0][BYTE_W-1:0] act;
    logic [PARTS-1:0][BYTE_W-1:0] scl;
    logic [PARTS-1:0][WGT_W-1:0]  wgt;

    // Accept while the queue has room, never during reset
    assign i_lane.ready = i_rst_n & ~i_q_status.full;
    assign o_push       = i_lane.valid & i_lane.ready;

    assign act = {i_lane.act_part3, i_lane.act_part2, i_lane.act_part1, i_lane.act_part0};
    assign scl = {i_lane.scale_part3, i_lane.scale_part2,
                  i_lane.scale_part1, i_lane.scale_part0};

    // Unpack the four weights of the lane
    always_comb begin
        logic [1:0] hi2;
        logic [3:0] nib;
        for (int p = 0; p < PARTS; p++) begin
            hi2 = i_lane.high_byte[2*p +: 2];
            case (p)
                0:       nib = i_lane.low_byte_a[3:0];
                1:       nib = i_lane.low_byte_b[3:0];
                2:       nib = i_lane.low_byte_a[7:4];
                default: nib = i_lane.low_byte_b[7:4];
            endcase
            if (i_fmt == FMT_SIX_BIT) begin
                wgt[p] = {1'b0, hi2, nib} - SIX_BIAS;
            end else begin
                wgt[p] = {5'b0, i_lane.low_byte_a[2*p +: 2]} - TERN_BIAS;
            end
        end
    end

    // Block ends on the flag or when the lane count runs out
    assign blk_end = i_lane.last_lane | (r_cnt == CNT_LAST);

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            n_cnt = blk_end ? '0 : r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_entry = '{fmt: i_fmt, blk_end: blk_end, wgt: wgt, act: act, scl: scl};

endmodule

// File: hw/rtl/qbdp_queue.sv
module qbdp_queue
    import qbdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_lane_entry i_entry,
    input  logic        i_pop,
    output t_lane_entry o_entry,
    output t_q_status   o_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_lane_entry      r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign o_status.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: hw/rtl/qbdp_back.sv
module qbdp_back
    import qbdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_lane_entry i_entry,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    qbdp_sum_if.source  o_sum
);

    logic                          en;
    logic                          r_s1_vld;
    logic                          r_s1_end;
    t_fmt                          r_s1_fmt;
    logic [PARTS-1:0][PROD1_W-1:0] r_s1_prod;
    logic [PARTS-1:0][BYTE_W-1:0]  r_s1_scl;
    logic                          r_s2_vld;
    logic                          r_s2_end;
    logic [PARTS-1:0][PROD2_W-1:0] r_s2_prod;
    logic signed [SUM_W-1:0]       r_acc;
    logic signed [SUM_W-1:0]       n_sum;
    logic                          r_out_vld;
    logic signed [SUM_W-1:0]       r_out_sum;
    logic [PARTS-1:0][PROD1_W-1:0] n_s1_prod;
    logic [PARTS-1:0][PROD2_W-1:0] n_s2_prod;

    // Whole pipe moves unless a result is held at the output
    assign en    = ~r_out_vld | o_sum.ready;
    assign o_pop = en & ~i_q_status.empty;

    // Stage 1 products: weight times activation
    always_comb begin
        for (int p = 0; p < PARTS; p++) begin
            n_s1_prod[p] = PROD1_W'($signed(i_entry.wgt[p])) *
                           PROD1_W'($signed(i_entry.act[p]));
        end
    end

    // Stage 2 products: apply the sub-block scale in six-bit format
    always_comb begin
        for (int p = 0; p < PARTS; p++) begin
            if (r_s1_fmt == FMT_SIX_BIT) begin
                n_s2_prod[p] = PROD2_W'($signed(r_s1_prod[p])) *
                               PROD2_W'($signed(r_s1_scl[p]));
            end else begin
                n_s2_prod[p] = PROD2_W'($signed(r_s1_prod[p]));
            end
        end
    end

    // Stage 3: add the four products into the running sum, wraps at SUM_W
    always_comb begin
        n_sum = r_acc;
        for (int p = 0; p < PARTS; p++) begin
            n_sum = n_sum + SUM_W'($signed(r_s2_prod[p]));
        end
    end

    // Control of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
        end else if (en) begin
            r_s1_vld  <= o_pop;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= r_s2_vld & r_s2_end;
            if (r_s2_vld) begin
                r_acc <= r_s2_end ? '0 : n_sum;
            end
        end
    end

    // Data of the stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_end  <= i_entry.blk_end;
            r_s1_fmt  <= i_entry.fmt;
            r_s1_prod <= n_s1_prod;
            r_s1_scl  <= i_entry.scl;
            r_s2_end  <= r_s1_end;
            r_s2_prod <= n_s2_prod;
            if (r_s2_vld && r_s2_end) begin
                r_out_sum <= n_sum;
            end
        end
    end

    assign o_sum.valid     = r_out_vld;
    assign o_sum.block_sum = r_out_sum;

endmodule

// File: hw/rtl/quantized_block_dot_product_unit.sv
// Channel   | Dir | Word                                         | Accepted when
// ----------+-----+----------------------------------------------+----------------------
// i_lane    | in  | weight bytes, 4 activations, 4 scales, last  | valid & ready
// o_sum     | out | 30-bit signed block dot product              | valid & ready
// i_cfg     | in  | weight_format (0 ternary, 1 six-bit)         | valid & ready
//
// One lane per cycle unless a held result stalls; the back end is a three-stage
// multiply-accumulate pipeline: stage 1 and stage 2 products, then the sum.
// i_cfg.ready is always high; format is sampled per lane at acceptance.
// Synchronous active-low reset clears the format, lane count, queue and sum.
// A held result stalls the back end; the four-entry queue then fills and
// drops i_lane.ready.
module quantized_block_dot_product_unit
    import qbdp_pkg::*;
#(
    parameter int LANES_PER_BLOCK = LANES_PER_BLOCK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qbdp_lane_if.sink  i_lane,
    qbdp_cfg_if.sink   i_cfg,
    qbdp_sum_if.source o_sum
);

    t_fmt        r_fmt;
    logic        push;
    logic        pop;
    t_lane_entry front_entry;
    t_lane_entry back_entry;
    t_q_status   q_status;

    // Weight format register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_TERNARY;
        end else if (i_cfg.valid) begin
            r_fmt <= t_fmt'(i_cfg.weight_format);
        end
    end

    qbdp_front #(
        .LANES_PER_BLOCK (LANES_PER_BLOCK)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fmt      (r_fmt),
        .i_lane     (i_lane),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (front_entry)
    );

    qbdp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (back_entry),
        .o_status (q_status)
    );

    qbdp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (back_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_sum      (o_sum)
    );

endmodule

// File: hw/rtl/qbdp_checker.sv
module qbdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [29:0] i_out_sum,
    input logic        i_cfg_ready
);

    // Reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A result needs a lane to pass the queue and three stages after reset
    a_min_latency: assert property (@(posedge i_clk)
        $rose(i_out_valid) |-> ($past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)))
        else $error("result appeared too soon after reset");

    // Held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sum)))
        else $error("stalled result changed");

    // Format writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind quantized_block_dot_product_unit qbdp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_sum.valid),
    .i_out_ready (o_sum.ready),
    .i_out_sum   (o_sum.block_sum),
    .i_cfg_ready (i_cfg.ready)
);
